// ----- hw/rtl/hcbd_pkg.sv -----
// Shared types and constants for the HTTP chunked body decoder.
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SIZE   = 3'd1,
        PH_DATA   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        HM_EMPTY = 2'd0,
        HM_CR    = 2'd1,
        HM_OTHER = 2'd2
    } hdr_mark_t;

    typedef enum logic [1:0] {
        PS_BLANK  = 2'd0,
        PS_DIGITS = 2'd1,
        PS_STOP   = 2'd2
    } parse_stage_t;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [15:0] LIMIT_RESET = 16'd30000;

    localparam int KIND_PAYLOAD = 0;
    localparam int KIND_END     = 1;

endpackage

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// HTTP chunked body decoder: strips headers and chunk framing, passes payload bytes.
// A result appears on the master side in the cycle after its byte transfer.
// Throughput: one byte per cycle unless output stalls; single registered state step.
// The output register frees in the same cycle it is taken, so there is no bubble.
// Reset: aresetn synchronous, active low; clears parse state and output valid,
// and sets payload_limit to 30000.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // payload_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] in_byte
    input  logic [0:0]  s_tuser,        // [0] start_response
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [7:0] data_byte, [23:8] total_bytes
    output logic [0:0]  m_tuser         // [0] kind
);
    import hcbd_pkg::*;

    logic [15:0]          limit_reg;
    phase_t               phase_reg, phase_next;
    hdr_mark_t            mark_reg, mark_next;
    parse_stage_t         stage_reg, stage_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic [15:0]          count_reg, count_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_kind_reg, m_kind_next;
    logic [7:0]           m_data_reg, m_data_next;
    logic [15:0]          m_total_reg, m_total_next;

    phase_t               cur_phase;
    hdr_mark_t            cur_mark;
    parse_stage_t         cur_stage;
    logic [SIZE_BITS-1:0] cur_acc;
    logic [SIZE_BITS-1:0] cur_chunk;
    logic [15:0]          cur_count;
    parse_stage_t         sp_stage;
    logic [SIZE_BITS-1:0] sp_acc;
    logic [15:0]          count_inc;
    logic [SIZE_BITS-1:0] chunk_dec;
    logic                 s_xfer;
    logic                 emit;
    logic                 is_lf;
    logic [7:0]           c;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign is_lf    = (c == CH_LF);

    // start of a new response clears state ahead of this byte
    always_comb begin
        if (s_tuser[0]) begin
            cur_phase = PH_HEADER;
            cur_mark  = HM_EMPTY;
            cur_stage = PS_BLANK;
            cur_acc   = '0;
            cur_chunk = '0;
            cur_count = '0;
        end else begin
            cur_phase = phase_reg;
            cur_mark  = mark_reg;
            cur_stage = stage_reg;
            cur_acc   = acc_reg;
            cur_chunk = chunk_reg;
            cur_count = count_reg;
        end
    end

    hcbd_size_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_size_parse (
        .in_byte    (c),
        .stage      (cur_stage),
        .acc        (cur_acc),
        .stage_next (sp_stage),
        .acc_next   (sp_acc)
    );

    assign count_inc = cur_count + 16'd1;
    assign chunk_dec = cur_chunk - SIZE_BITS'(1);

    always_comb begin
        phase_next  = cur_phase;
        mark_next   = cur_mark;
        stage_next  = cur_stage;
        acc_next    = cur_acc;
        chunk_next  = cur_chunk;
        count_next  = cur_count;
        emit        = 1'b0;
        m_kind_next = 1'(KIND_PAYLOAD);
        m_data_next = 8'd0;
        m_total_next = cur_count;
        case (cur_phase)
            PH_HEADER: begin
                if (is_lf) begin
                    if (cur_mark == HM_CR) begin
                        phase_next = PH_SIZE;
                        stage_next = PS_BLANK;
                        acc_next   = '0;
                    end
                    mark_next = HM_EMPTY;
                end else if (cur_mark == HM_EMPTY && c == CH_CR) begin
                    mark_next = HM_CR;
                end else begin
                    mark_next = HM_OTHER;
                end
            end
            PH_SIZE: begin
                if (is_lf) begin
                    if (cur_acc == '0) begin
                        phase_next  = PH_DONE;
                        emit        = 1'b1;
                        m_kind_next = 1'(KIND_END);
                    end else begin
                        chunk_next = cur_acc;
                        phase_next = (cur_count >= limit_reg) ? PH_SKIP : PH_DATA;
                    end
                end else begin
                    stage_next = sp_stage;
                    acc_next   = sp_acc;
                end
            end
            PH_DATA: begin
                if (cur_chunk == '0 || cur_count >= limit_reg) begin
                    phase_next = PH_SKIP;
                    if (is_lf) begin
                        phase_next = PH_SIZE;
                        stage_next = PS_BLANK;
                        acc_next   = '0;
                    end
                end else begin
                    count_next   = count_inc;
                    chunk_next   = chunk_dec;
                    if (chunk_dec == '0 || count_inc >= limit_reg) begin
                        phase_next = PH_SKIP;
                    end
                    emit         = 1'b1;
                    m_data_next  = c;
                    m_total_next = count_inc;
                end
            end
            PH_SKIP: begin
                if (is_lf) begin
                    phase_next = PH_SIZE;
                    stage_next = PS_BLANK;
                    acc_next   = '0;
                end
            end
            default: begin
                phase_next = cur_phase;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            phase_reg   <= PH_HEADER;
            mark_reg    <= HM_EMPTY;
            stage_reg   <= PS_BLANK;
            acc_reg     <= '0;
            chunk_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                phase_reg <= phase_next;
                mark_reg  <= mark_next;
                stage_reg <= stage_next;
                acc_reg   <= acc_next;
                chunk_reg <= chunk_next;
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            m_kind_reg  <= m_kind_next;
            m_data_reg  <= m_data_next;
            m_total_reg <= m_total_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_data_reg};
    assign m_tuser  = m_kind_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !s_tuser[0] && phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left done phase without start_response");

    a_end_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("end result carries nonzero data byte");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !s_tuser[0] |=> count_reg == $past(count_reg)
            || count_reg == $past(count_reg) + 16'd1)
        else $error("payload count jumped");

endmodule

// ----- hw/rtl/hcbd_size_parse.sv -----
// Chunk-size line parser: one byte step of the hex size accumulator.
module hcbd_size_parse #(
    parameter int SIZE_BITS = 24
) (
    input  logic [7:0]                   in_byte,
    input  hcbd_pkg::parse_stage_t       stage,
    input  logic [SIZE_BITS-1:0]         acc,
    output hcbd_pkg::parse_stage_t       stage_next,
    output logic [SIZE_BITS-1:0]         acc_next
);
    import hcbd_pkg::*;

    logic       is_hex;
    logic [3:0] digit;
    logic       is_blank;
    logic       sat;

    always_comb begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (in_byte >= "0" && in_byte <= "9") begin
            digit = 4'(in_byte - "0");
        end else if (in_byte >= "a" && in_byte <= "f") begin
            digit = 4'(in_byte - "a" + 8'd10);
        end else if (in_byte >= "A" && in_byte <= "F") begin
            digit = 4'(in_byte - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign is_blank = (in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_VT)
                   || (in_byte == CH_FF) || (in_byte == CH_CR);

    // shifting left by a nibble overflows iff the top nibble is nonzero
    assign sat = |acc[SIZE_BITS-1 -: 4];

    always_comb begin
        stage_next = stage;
        acc_next   = acc;
        case (stage)
            PS_BLANK: begin
                if (is_hex) begin
                    acc_next   = SIZE_BITS'(digit);
                    stage_next = PS_DIGITS;
                end else if (!is_blank) begin
                    stage_next = PS_STOP;
                end
            end
            PS_DIGITS: begin
                if (is_hex) begin
                    acc_next = sat ? {SIZE_BITS{1'b1}} : {acc[SIZE_BITS-5:0], digit};
                end else begin
                    stage_next = PS_STOP;
                end
            end
            default: begin
                stage_next = stage;
            end
        endcase
    end

endmodule
